FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, removed when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked on every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: src/ccov_pkg.sv
// ----------------------------------------------------------------------------
// ccov_pkg
// shared constants for the capsule overlap pipeline
// ----------------------------------------------------------------------------
package ccov_pkg;

  // default geometry formats
  localparam int COORD_WIDTH_DEF     = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // fixed port field widths
  localparam int POINT_W = 48;
  localparam int RAD_W   = 16;
  localparam int DIST_W  = 34;
  localparam int PARAM_W = 17;

endpackage

FILE: src/ccov_delay.sv
// ----------------------------------------------------------------------------
// ccov_delay
// enabled shift line carrying side data alongside the pipeline
// ----------------------------------------------------------------------------
module ccov_delay
  import ccov_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] stage_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r[0] <= d;
    end
  end

  for (genvar i = 1; i < DEPTH; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[i] <= stage_r[i-1];
      end
    end
  end

  assign q = stage_r[DEPTH-1];

endmodule

FILE: src/ccov_div.sv
// ----------------------------------------------------------------------------
// ccov_div
// pipelined restoring divider, quotient clamped to [0,1], one bit per stage
// ----------------------------------------------------------------------------
module ccov_div
  import ccov_pkg::*;
#(
  parameter int W    = 74,
  parameter int FRAC = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  output logic [FRAC:0]       q
);

  localparam logic [FRAC:0] ONE = {1'b1, {FRAC{1'b0}}};

  logic [W-1:0]  rem_r  [FRAC+1];
  logic [W-1:0]  den_r  [FRAC+1];
  logic [FRAC:0] q_r    [FRAC+1];
  logic          done_r [FRAC+1];

  // range check: non-positive gives zero, at least one gives one
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      if (num <= 0) begin
        done_r[0] <= 1'b1;
      end else if (num >= den) begin
        done_r[0] <= 1'b1;
        q_r[0]    <= ONE;
      end else begin
        done_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 1; i <= FRAC; i++) begin : g_step
    logic [W-1:0] sh;
    logic         ge;
    assign sh = {rem_r[i-1][W-2:0], 1'b0};
    assign ge = (sh >= den_r[i-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i]  <= den_r[i-1];
        done_r[i] <= done_r[i-1];
        if (done_r[i-1]) begin
          rem_r[i] <= rem_r[i-1];
          q_r[i]   <= q_r[i-1];
        end else begin
          rem_r[i] <= ge ? (sh - den_r[i-1]) : sh;
          q_r[i]   <= {q_r[i-1][FRAC-1:0], ge};
        end
      end
    end
  end

  assign q = q_r[FRAC];

endmodule

FILE: src/capsule_capsule_overlap.sv
// ----------------------------------------------------------------------------
// capsule_capsule_overlap
// closest points of two 3d segments and capsule overlap, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   input request: two segments (start/end points packed x,y,z with x lowest,
//   signed fixed point) and two radii, taken when in_valid is high and
//   in_stall is low
//   result request: squared distance of the closest points, both clamped
//   segment parameters and the overlap flag, taken when out_valid is high
//   and out_stall is low
//   a zero-length second segment gives a capsule against sphere test
// timing
//   one request per cycle sustained while no result is held by out_stall; the
//   depth is set mostly by the two bit-per-stage dividers for s and t
//   all stages advance together; while a result is held by out_stall the
//   whole pipeline freezes and in_stall is raised, nothing is lost
// reset
//   synchronous rst_n clears every valid bit; payload registers are not reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module capsule_capsule_overlap
  import ccov_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [POINT_W-1:0] in_seg_a_start,
  input  logic [POINT_W-1:0] in_seg_a_end,
  input  logic [POINT_W-1:0] in_seg_b_start,
  input  logic [POINT_W-1:0] in_seg_b_end,
  input  logic [RAD_W-1:0]   in_radius_a,
  input  logic [RAD_W-1:0]   in_radius_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIST_W-1:0]  out_dist_sq,
  output logic [PARAM_W-1:0] out_param_a,
  output logic [PARAM_W-1:0] out_param_b,
  output logic               out_hit
);

  localparam int CW     = COORD_WIDTH;
  localparam int PF     = PARAM_FRAC_BITS;
  localparam int PACK_W = 3 * CW;
  localparam int D      = CW + 1;            // coordinate difference
  localparam int P      = 2 * D;             // one coordinate product
  localparam int DOT    = P + 2;             // three-term dot product
  localparam int MW     = 2 * DOT;           // product of two dots
  localparam int WN     = MW + 2;            // divider operands
  localparam int VW     = D + PF + 2;        // closest-point difference
  localparam int QW     = VW - PF;           // rounded difference
  localparam int DW     = 2 * QW + 2;        // exact squared distance
  localparam int CMP_W  = (DW > DIST_W) ? DW : DIST_W;
  localparam int RS_W   = 2 * (RAD_W + 1);
  localparam int GEO_W  = 9 * D;
  localparam int DOTS_W = 5 * DOT;
  localparam int N      = 13 + 2 * PF;       // pipeline depth

  localparam logic [PF:0]       ONE      = {1'b1, {PF{1'b0}}};
  localparam logic [CMP_W-1:0]  DIST_MAX = CMP_W'({DIST_W{1'b1}});
  localparam logic signed [VW-1:0] HALF  = VW'(1) <<< (PF - 1);

  // global advance: everything moves unless a held result blocks the output
  logic         en;
  logic [N-1:0] vld_r;

  assign en       = !vld_r[N-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  // ---- stage 1: unpack, segment directions and start offset
  logic [PACK_W-1:0] pa0, pa1, pb0, pb1;
  logic signed [D-1:0] d1_r [3];
  logic signed [D-1:0] d2_r [3];
  logic signed [D-1:0] rr_r [3];
  logic [RAD_W:0]      rsum_r;

  assign pa0 = PACK_W'(in_seg_a_start);
  assign pa1 = PACK_W'(in_seg_a_end);
  assign pb0 = PACK_W'(in_seg_b_start);
  assign pb1 = PACK_W'(in_seg_b_end);

  for (genvar k = 0; k < 3; k++) begin : g_s1
    logic signed [CW-1:0] ca0, ca1, cb0, cb1;
    assign ca0 = $signed(pa0[k*CW +: CW]);
    assign ca1 = $signed(pa1[k*CW +: CW]);
    assign cb0 = $signed(pb0[k*CW +: CW]);
    assign cb1 = $signed(pb1[k*CW +: CW]);
    always_ff @(posedge clk) begin
      if (en) begin
        d1_r[k] <= D'(ca1) - D'(ca0);
        d2_r[k] <= D'(cb1) - D'(cb0);
        rr_r[k] <= D'(ca0) - D'(cb0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsum_r <= (RAD_W+1)'(in_radius_a) + (RAD_W+1)'(in_radius_b);
    end
  end

  logic [GEO_W-1:0] geo_s1, geo_d;
  for (genvar k = 0; k < 3; k++) begin : g_geo
    assign geo_s1[k*D +: D]       = d1_r[k];
    assign geo_s1[(3+k)*D +: D]   = d2_r[k];
    assign geo_s1[(6+k)*D +: D]   = rr_r[k];
  end

  // geometry rides along to the closest-point stage
  ccov_delay #(.W(GEO_W), .DEPTH(8 + 2*PF)) u_geo_dly (
    .clk (clk), .en (en), .d (geo_s1), .q (geo_d)
  );

  // ---- stage 2: coordinate products, radius sum squared
  logic signed [P-1:0] p_aa_r [3];
  logic signed [P-1:0] p_ee_r [3];
  logic signed [P-1:0] p_bb_r [3];
  logic signed [P-1:0] p_cc_r [3];
  logic signed [P-1:0] p_ff_r [3];
  logic [RS_W-1:0]     rs2_r, rs2_d;

  for (genvar k = 0; k < 3; k++) begin : g_s2
    always_ff @(posedge clk) begin
      if (en) begin
        p_aa_r[k] <= d1_r[k] * d1_r[k];
        p_ee_r[k] <= d2_r[k] * d2_r[k];
        p_bb_r[k] <= d1_r[k] * d2_r[k];
        p_cc_r[k] <= d1_r[k] * rr_r[k];
        p_ff_r[k] <= d2_r[k] * rr_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs2_r <= rsum_r * rsum_r;
    end
  end

  ccov_delay #(.W(RS_W), .DEPTH(10 + 2*PF)) u_rs_dly (
    .clk (clk), .en (en), .d (rs2_r), .q (rs2_d)
  );

  // ---- stage 3: dot products
  logic signed [DOT-1:0] a_r, e_r, b_r, c_r, f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= DOT'(p_aa_r[0]) + DOT'(p_aa_r[1]) + DOT'(p_aa_r[2]);
      e_r <= DOT'(p_ee_r[0]) + DOT'(p_ee_r[1]) + DOT'(p_ee_r[2]);
      b_r <= DOT'(p_bb_r[0]) + DOT'(p_bb_r[1]) + DOT'(p_bb_r[2]);
      c_r <= DOT'(p_cc_r[0]) + DOT'(p_cc_r[1]) + DOT'(p_cc_r[2]);
      f_r <= DOT'(p_ff_r[0]) + DOT'(p_ff_r[1]) + DOT'(p_ff_r[2]);
    end
  end

  logic [DOTS_W-1:0] dots_s3, dots_d;
  assign dots_s3 = {a_r, e_r, b_r, c_r, f_r};

  ccov_delay #(.W(DOTS_W), .DEPTH(3 + PF)) u_dots_dly (
    .clk (clk), .en (en), .d (dots_s3), .q (dots_d)
  );

  // ---- stage 4: wide products for the denominator and s numerator
  logic signed [MW-1:0] ae_r, bb_r, bf_r, ce_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ae_r <= a_r * e_r;
      bb_r <= b_r * b_r;
      bf_r <= b_r * f_r;
      ce_r <= c_r * e_r;
    end
  end

  // ---- stage 5: denominator and numerator of s
  logic signed [WN-1:0] den_nxt, snum_r, sden_r;
  logic                 den_zero_r, den_zero_d;

  assign den_nxt = WN'(ae_r) - WN'(bb_r);

  always_ff @(posedge clk) begin
    if (en) begin
      snum_r     <= WN'(bf_r) - WN'(ce_r);
      // parallel segments: divider result is discarded, keep it well formed
      sden_r     <= (den_nxt == 0) ? WN'(1) : den_nxt;
      den_zero_r <= (den_nxt == 0);
    end
  end

  ccov_delay #(.W(1), .DEPTH(PF + 1)) u_dz_dly (
    .clk (clk), .en (en), .d (den_zero_r), .q (den_zero_d)
  );

  // ---- first divider: unclamped s
  logic [PF:0] s1;

  ccov_div #(.W(WN), .FRAC(PF)) u_div_s (
    .clk (clk), .en (en), .num (snum_r), .den (sden_r), .q (s1)
  );

  // ---- stage 6: t numerator from the quantised s
  logic signed [DOT-1:0]      ad, ed, bd, cd, fd;
  logic [PF:0]                s_use;
  logic signed [DOT+PF+1:0]   bs;
  logic signed [WN-1:0]       tn_r, td_r;
  logic signed [DOT-1:0]      a6_r, b6_r, c6_r, e6_r, f6_r;
  logic [PF:0]                s6_r;

  assign {ad, ed, bd, cd, fd} = dots_d;
  assign s_use = den_zero_d ? '0 : s1;
  assign bs    = bd * $signed({1'b0, s_use});

  always_ff @(posedge clk) begin
    if (en) begin
      tn_r <= WN'(bs) + (WN'(fd) <<< PF);
      td_r <= WN'(ed) <<< PF;
      a6_r <= ad;
      b6_r <= bd;
      c6_r <= cd;
      e6_r <= ed;
      f6_r <= fd;
      s6_r <= s_use;
    end
  end

  // ---- stage 7: pick the second division and the fixed parameter
  logic signed [WN-1:0] num2_nxt, den2_nxt, num2_r, den2_r;
  logic                 sel_t_nxt;
  logic [PF:0]          sfix_nxt, tfix_nxt;
  logic [2*PF+2:0]      side_r, side_d;

  always_comb begin
    num2_nxt  = '0;
    den2_nxt  = WN'(1);
    sel_t_nxt = 1'b0;
    sfix_nxt  = '0;
    tfix_nxt  = '0;
    if (a6_r == 0 && e6_r == 0) begin
      // both points: divider gives zero for s
      sel_t_nxt = 1'b0;
    end else if (a6_r == 0) begin
      sel_t_nxt = 1'b1;
      num2_nxt  = WN'(f6_r);
      den2_nxt  = WN'(e6_r);
    end else if (e6_r == 0) begin
      num2_nxt  = -WN'(c6_r);
      den2_nxt  = WN'(a6_r);
    end else if (tn_r < 0) begin
      // t below zero: clamp and refit s
      num2_nxt  = -WN'(c6_r);
      den2_nxt  = WN'(a6_r);
    end else if (tn_r > td_r) begin
      // t above one: clamp and refit s
      tfix_nxt  = ONE;
      num2_nxt  = WN'(b6_r) - WN'(c6_r);
      den2_nxt  = WN'(a6_r);
    end else begin
      sel_t_nxt = 1'b1;
      sfix_nxt  = s6_r;
      num2_nxt  = tn_r;
      den2_nxt  = td_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2_r <= num2_nxt;
      den2_r <= den2_nxt;
      side_r <= {sel_t_nxt, sfix_nxt, tfix_nxt};
    end
  end

  ccov_delay #(.W(2*PF + 3), .DEPTH(PF + 1)) u_side_dly (
    .clk (clk), .en (en), .d (side_r), .q (side_d)
  );

  // ---- second divider: t, or s refitted against a clamped t
  logic [PF:0] q2, s_fin, t_fin, sfix_d, tfix_d;
  logic        sel_t_d;

  ccov_div #(.W(WN), .FRAC(PF)) u_div_t (
    .clk (clk), .en (en), .num (num2_r), .den (den2_r), .q (q2)
  );

  assign {sel_t_d, sfix_d, tfix_d} = side_d;
  assign s_fin = sel_t_d ? sfix_d : q2;
  assign t_fin = sel_t_d ? q2 : tfix_d;

  // ---- stage 8: closest-point difference terms
  logic signed [VW-1:0] pr_r [3];
  logic signed [VW-1:0] p1_r [3];
  logic signed [VW-1:0] p2_r [3];
  logic [PF:0]          s8_r, t8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_r <= s_fin;
      t8_r <= t_fin;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_s8
    logic signed [D-1:0] gd1, gd2, gr;
    assign gd1 = $signed(geo_d[k*D +: D]);
    assign gd2 = $signed(geo_d[(3+k)*D +: D]);
    assign gr  = $signed(geo_d[(6+k)*D +: D]);
    always_ff @(posedge clk) begin
      if (en) begin
        pr_r[k] <= VW'(gr) <<< PF;
        p1_r[k] <= gd1 * $signed({1'b0, s_fin});
        p2_r[k] <= gd2 * $signed({1'b0, t_fin});
      end
    end
  end

  // ---- stage 9: sum and round to coordinate fraction, ties up
  logic signed [QW-1:0] qd_r [3];
  logic [PF:0]          s9_r, t9_r;

  for (genvar k = 0; k < 3; k++) begin : g_s9
    logic signed [VW-1:0] vsum;
    assign vsum = pr_r[k] + p1_r[k] - p2_r[k] + HALF;
    always_ff @(posedge clk) begin
      if (en) begin
        qd_r[k] <= QW'(vsum >>> PF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_r <= s8_r;
      t9_r <= t8_r;
    end
  end

  // ---- stage 10: squares
  logic [2*QW-1:0] sq_r [3];
  logic [PF:0]     s10_r, t10_r;

  for (genvar k = 0; k < 3; k++) begin : g_s10
    logic signed [2*QW-1:0] sqs;
    assign sqs = qd_r[k] * qd_r[k];
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k] <= $unsigned(sqs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_r <= s9_r;
      t10_r <= t9_r;
    end
  end

  // ---- stage 11: distance, saturation, overlap flag
  logic [DW-1:0]      dist_sum;
  logic [CMP_W-1:0]   dist_ext;
  logic [DIST_W-1:0]  dist_r;
  logic [PARAM_W-1:0] pa_r, pb_r;
  logic               hit_r;

  assign dist_sum = DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);
  assign dist_ext = CMP_W'(dist_sum);

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (dist_ext > DIST_MAX) ? {DIST_W{1'b1}} : DIST_W'(dist_ext);
      hit_r  <= (dist_ext <= CMP_W'(rs2_d));
      pa_r   <= PARAM_W'(s10_r);
      pb_r   <= PARAM_W'(t10_r);
    end
  end

  assign out_valid   = vld_r[N-1];
  assign out_dist_sq = dist_r;
  assign out_param_a = pa_r;
  assign out_param_b = pb_r;
  assign out_hit     = hit_r;

  // ---- checks
  `ASSERT_CLK(a_hold_blocks_input, clk, rst_n, (out_valid && out_stall) |-> in_stall)
  `ASSERT_CLK(a_held_result_stays, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_dist_sq) && $stable(out_param_a)))
  `ASSERT_CLK(a_param_a_range, clk, rst_n, out_valid |-> (out_param_a <= PARAM_W'(ONE)))
  `ASSERT_CLK(a_param_b_range, clk, rst_n, out_valid |-> (out_param_b <= PARAM_W'(ONE)))
  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid)

endmodule
